/* rtl/core/mwu_pkg.sv */
// Shared constants, types and scaling helpers for the momentum weight update block.
package mwu_pkg;

    // Table and number format
    localparam int TABLE_DEPTH      = 4096;
    localparam int INDEX_BITS       = $clog2(TABLE_DEPTH);
    localparam int INDEX_FIELD_BITS = 12;
    localparam int WORD_BITS        = 16;
    localparam int REG_BITS         = 15;
    localparam int FIXED_SCALE      = 1024;          // must be a power of two
    localparam int SCALE_SHIFT      = $clog2(FIXED_SCALE);
    localparam int RAM_BITS         = 2 * WORD_BITS; // {weight, change}

    // Product widths through the update pipeline
    localparam int P1_BITS = REG_BITS + WORD_BITS + 1; // gain * signed word
    localparam int T1_BITS = P1_BITS - SCALE_SHIFT;    // after scaling
    localparam int P2_BITS = T1_BITS + WORD_BITS;      // t1 * source output

    // APB register map
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic {
        REG_LEARN    = 1'b0,
        REG_MOMENTUM = 1'b1
    } t_reg_sel;

    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_UPDATE = 1'b1
    } t_kind;

    typedef struct packed {
        logic [REG_BITS-1:0] learning_gain;
        logic [REG_BITS-1:0] momentum_gain;
    } t_cfg;

    typedef struct packed {
        logic                  re;
        logic [INDEX_BITS-1:0] raddr;
        logic                  we;
        logic [INDEX_BITS-1:0] waddr;
        logic [RAM_BITS-1:0]   wdata;
    } t_ram_req;

    // Division by the scale, truncating toward zero: floor shift, plus one for
    // a negative value with a non-zero remainder.
    function automatic logic signed [T1_BITS-1:0] div_scale_p1(
        input logic signed [P1_BITS-1:0] a
    );
        logic signed [T1_BITS-1:0] q;
        q = a[P1_BITS-1:SCALE_SHIFT];
        if (a[P1_BITS-1] && (a[SCALE_SHIFT-1:0] != '0)) begin
            q = q + T1_BITS'(1);
        end
        return q;
    endfunction

    // Same rounding on the wide product; only the low word is kept.
    function automatic logic [WORD_BITS-1:0] div_scale_p2(
        input logic signed [P2_BITS-1:0] a
    );
        logic [WORD_BITS-1:0] q;
        q = a[SCALE_SHIFT+WORD_BITS-1:SCALE_SHIFT];
        if (a[P2_BITS-1] && (a[SCALE_SHIFT-1:0] != '0)) begin
            q = q + WORD_BITS'(1);
        end
        return q;
    endfunction

endpackage

/* rtl/core/mwu_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module mwu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first; read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/mwu_cfg.sv */
// APB register file holding the learning rate and momentum gain.
module mwu_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mwu_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [mwu_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [mwu_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    output mwu_pkg::t_cfg                     o_cfg
);
    import mwu_pkg::*;

    logic [REG_BITS-1:0] r_learning_gain;
    logic [REG_BITS-1:0] r_momentum_gain;
    logic                wr_en;
    t_reg_sel            sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = t_reg_sel'(paddr[2]);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learning_gain <= '0;
            r_momentum_gain <= '0;
        end else if (wr_en) begin
            case (sel)
                REG_LEARN:    r_learning_gain <= pwdata[REG_BITS-1:0];
                REG_MOMENTUM: r_momentum_gain <= pwdata[REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (sel)
            REG_LEARN:    prdata = APB_DATA_BITS'(r_learning_gain);
            REG_MOMENTUM: prdata = APB_DATA_BITS'(r_momentum_gain);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.learning_gain = r_learning_gain;
    assign o_cfg.momentum_gain = r_momentum_gain;

endmodule

/* rtl/core/mwu_pipe.sv */
// Update pipeline: table read, scaled multiplies, write-back and output register.
module mwu_pipe (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mwu_pkg::t_cfg                        i_cfg,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_kind,
    input  logic [mwu_pkg::INDEX_FIELD_BITS-1:0] i_weight_index,
    input  logic signed [mwu_pkg::WORD_BITS-1:0] i_load_value,
    input  logic signed [mwu_pkg::WORD_BITS-1:0] i_target_delta,
    input  logic signed [mwu_pkg::WORD_BITS-1:0] i_source_output,
    output mwu_pkg::t_ram_req                    o_ram_req,
    input  logic [mwu_pkg::RAM_BITS-1:0]         i_ram_rdata,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [mwu_pkg::WORD_BITS-1:0] o_new_weight,
    output logic signed [mwu_pkg::WORD_BITS-1:0] o_weight_change
);
    import mwu_pkg::*;

    typedef struct packed {
        t_kind                      kind;
        logic [INDEX_BITS-1:0]      idx;
        logic signed [WORD_BITS-1:0] load_value;
        logic signed [WORD_BITS-1:0] source_output;
        logic signed [P1_BITS-1:0]   p1;
    } t_s1;

    typedef struct packed {
        t_kind                       kind;
        logic [INDEX_BITS-1:0]       idx;
        logic [WORD_BITS-1:0]        weight;
        logic signed [WORD_BITS-1:0] source_output;
        logic signed [T1_BITS-1:0]   t1;
        logic signed [P1_BITS-1:0]   p3;
    } t_s2;

    typedef struct packed {
        t_kind                     kind;
        logic [INDEX_BITS-1:0]     idx;
        logic [WORD_BITS-1:0]      weight;
        logic signed [P2_BITS-1:0] p2;
        logic [WORD_BITS-1:0]      t3;
    } t_s3;

    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    logic [WORD_BITS-1:0] r_out_weight, n_out_weight;
    logic [WORD_BITS-1:0] r_out_change, n_out_change;

    logic                        advance;
    logic                        hazard;
    logic                        accept;
    logic [INDEX_BITS-1:0]       in_idx;
    logic signed [WORD_BITS-1:0] prev_change;
    logic signed [T1_BITS-1:0]   t3_full;
    logic [WORD_BITS-1:0]        t2;

    // Flow control: whole pipeline moves when the output register is free
    assign advance = !r_out_valid || i_out_ready;
    assign in_idx  = i_weight_index[INDEX_BITS-1:0];

    // Interlock: an update waits while an earlier item on the same entry
    // has not yet written back
    assign hazard = (i_kind == KIND_UPDATE) &&
                    ((r_s1_valid && (r_s1.idx == in_idx)) ||
                     (r_s2_valid && (r_s2.idx == in_idx)) ||
                     (r_s3_valid && (r_s3.idx == in_idx)));

    assign o_in_ready = advance && !hazard;
    assign accept     = i_in_valid && o_in_ready;

    // Stage 1: learning-rate product, table read issued
    always_comb begin
        n_s1.kind          = t_kind'(i_kind);
        n_s1.idx           = in_idx;
        n_s1.load_value    = i_load_value;
        n_s1.source_output = i_source_output;
        n_s1.p1            = P1_BITS'($signed({1'b0, i_cfg.learning_gain})) *
                             P1_BITS'(i_target_delta);
    end

    // Stage 2: scale t1, momentum product on the stored change
    assign prev_change = $signed(i_ram_rdata[WORD_BITS-1:0]);

    always_comb begin
        n_s2.kind          = r_s1.kind;
        n_s2.idx           = r_s1.idx;
        n_s2.weight        = (r_s1.kind == KIND_LOAD) ? r_s1.load_value
                                                      : i_ram_rdata[RAM_BITS-1:WORD_BITS];
        n_s2.source_output = r_s1.source_output;
        n_s2.t1            = div_scale_p1(r_s1.p1);
        n_s2.p3            = P1_BITS'($signed({1'b0, i_cfg.momentum_gain})) *
                             P1_BITS'(prev_change);
    end

    // Stage 3: t1 times source output, scale momentum term
    assign t3_full = div_scale_p1(r_s2.p3);

    always_comb begin
        n_s3.kind   = r_s2.kind;
        n_s3.idx    = r_s2.idx;
        n_s3.weight = r_s2.weight;
        n_s3.p2     = P2_BITS'(r_s2.t1) * P2_BITS'(r_s2.source_output);
        n_s3.t3     = t3_full[WORD_BITS-1:0];
    end

    // Final: step and new weight, wrapped to the word
    assign t2 = div_scale_p2(r_s3.p2);

    always_comb begin
        if (r_s3.kind == KIND_LOAD) begin
            n_out_change = '0;
            n_out_weight = r_s3.weight;
        end else begin
            n_out_change = t2 + r_s3.t3;
            n_out_weight = r_s3.weight + n_out_change;
        end
    end

    // Table access
    always_comb begin
        o_ram_req.re    = accept;
        o_ram_req.raddr = in_idx;
        o_ram_req.we    = advance && r_s3_valid;
        o_ram_req.waddr = r_s3.idx;
        o_ram_req.wdata = {n_out_weight, n_out_change};
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= accept;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1         <= n_s1;
            r_s2         <= n_s2;
            r_s3         <= n_s3;
            r_out_weight <= n_out_weight;
            r_out_change <= n_out_change;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_new_weight    = $signed(r_out_weight);
    assign o_weight_change = $signed(r_out_change);

endmodule

/* rtl/core/momentum_weight_update.sv */
// Top level of the momentum weight update block: registers, pipeline and weight table.
//
// Back-propagation weight update with momentum in 16-bit scaled integers
// (1024 stands for 1.0). A load request writes a weight and clears its stored
// change; an update request computes
// step = (learning_gain*delta/S)*output/S + momentum_gain*previous_change/S with
// truncating division, wraps it to 16 bits, stores it and adds it to the
// weight. Each weight and its change share one word of a 4096-entry table with
// a registered read. One request is taken per clock while the output register
// is free and no update waits; the result passes through stages 1, 2 and 3 and
// the output register. An update to an entry still held by one of the three
// compute stages waits until that earlier request has written back, because
// the table is read at acceptance and written at the end of the pipeline.
// Entries are undefined until loaded; there is no clearing pass after reset.
// The user writes learning_gain (address 0) and momentum_gain (address 4) through
// the APB port only while no request is in flight; the block does not enforce it.
module momentum_weight_update (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mwu_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [mwu_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [mwu_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_kind,
    input  logic [mwu_pkg::INDEX_FIELD_BITS-1:0] i_weight_index,
    input  logic signed [mwu_pkg::WORD_BITS-1:0] i_load_value,
    input  logic signed [mwu_pkg::WORD_BITS-1:0] i_target_delta,
    input  logic signed [mwu_pkg::WORD_BITS-1:0] i_source_output,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [mwu_pkg::WORD_BITS-1:0] o_new_weight,
    output logic signed [mwu_pkg::WORD_BITS-1:0] o_weight_change
);
    import mwu_pkg::*;

    t_cfg                cfg;
    t_ram_req            ram_req;
    logic [RAM_BITS-1:0] ram_rdata;

    // Configuration registers
    mwu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Update pipeline
    mwu_pipe u_pipe (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_weight_index  (i_weight_index),
        .i_load_value    (i_load_value),
        .i_target_delta  (i_target_delta),
        .i_source_output (i_source_output),
        .o_ram_req       (ram_req),
        .i_ram_rdata     (ram_rdata),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_new_weight    (o_new_weight),
        .o_weight_change (o_weight_change)
    );

    // Weight and change table
    mwu_ram #(
        .WIDTH (RAM_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

endmodule
